@@ src/tla_pkg.sv @@
// tla_pkg: shared constants for the telnet line assembler.
// Parse mode codes, telnet byte codes, event kinds and parameter defaults.
// No dependencies.
package tla_pkg;

  // parameter defaults
  localparam int CHANNELS_DEFAULT = 256;
  localparam int LINE_MAX_DEFAULT = 1024;

  // payload widths
  localparam int CHAN_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 3;

  // per-channel parse modes
  localparam logic [MODE_W-1:0] M_TEXT = 3'd0;
  localparam logic [MODE_W-1:0] M_IAC  = 3'd1;
  localparam logic [MODE_W-1:0] M_SKIP = 3'd3;
  localparam logic [MODE_W-1:0] M_DO   = 3'd4;

  // telnet command and option bytes
  localparam logic [BYTE_W-1:0] B_IAC     = 8'hFF;
  localparam logic [BYTE_W-1:0] B_DONT    = 8'hFE;
  localparam logic [BYTE_W-1:0] B_DO      = 8'hFD;
  localparam logic [BYTE_W-1:0] B_WONT    = 8'hFC;
  localparam logic [BYTE_W-1:0] B_WILL    = 8'hFB;
  localparam logic [BYTE_W-1:0] B_EL      = 8'hF8;
  localparam logic [BYTE_W-1:0] B_AYT     = 8'hF6;
  localparam logic [BYTE_W-1:0] B_IP      = 8'hF4;
  localparam logic [BYTE_W-1:0] OPT_TM    = 8'h06;
  localparam logic [BYTE_W-1:0] OPT_SGA   = 8'h03;
  localparam logic [BYTE_W-1:0] B_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] B_SPACE   = 8'h20;

  // event kinds
  localparam logic [KIND_W-1:0] EV_KEEP      = 3'd0;
  localparam logic [KIND_W-1:0] EV_ERASE     = 3'd1;
  localparam logic [KIND_W-1:0] EV_LINE_END  = 3'd2;
  localparam logic [KIND_W-1:0] EV_LINE_FULL = 3'd3;
  localparam logic [KIND_W-1:0] EV_AYT       = 3'd4;
  localparam logic [KIND_W-1:0] EV_WILL_TM   = 3'd5;
  localparam logic [KIND_W-1:0] EV_WILL_SGA  = 3'd6;
  localparam logic [KIND_W-1:0] EV_DISCONN   = 3'd7;

endpackage

@@ src/tla_if.sv @@
// tla_if: valid/ready channel interfaces for the telnet line assembler.
// Input word carries channel and byte, output word carries one event.
// Depends on tla_pkg.
interface tla_in_if
  import tla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output channel, output rx_byte, input ready);
  modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

interface tla_out_if
  import tla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] char_out;

  modport source (output valid, output out_channel, output event_kind, output char_out,
                  input ready);
  modport sink   (input valid, input out_channel, input event_kind, input char_out,
                  output ready);
endinterface

@@ src/telnet_line_assembler.sv @@
// telnet_line_assembler: per-channel telnet command stripper and line assembler.
// Words pass stage 1 (state read) and then the output register, where the event waits to be taken.
// Throughput: one word per cycle (one state read and one write-back per cycle, forwarded
// between back-to-back words on one channel); input stalls while a waiting event blocks or the clearing pass runs.
// Reset: synchronous; afterwards a clearing pass over every channel address zeroes the
// state memory, and no word is accepted until it finishes.
module telnet_line_assembler
  import tla_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT,
  parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  tla_in_if.sink    rx,
  tla_out_if.source events
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(LINE_MAX);
  localparam int EW = MODE_W + CW;
  localparam logic [CW-1:0] COUNT_LAST = CW'(LINE_MAX - 1);

  // clearing pass
  logic          sweeping;
  logic [AW-1:0] sweep_addr;

  // stage 1: item whose state read is in flight
  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  logic [CHAN_W-1:0] s1_chan;
  logic [BYTE_W-1:0] s1_byte;
  logic              byp_hit;
  logic [EW-1:0]     byp_data;

  // output register
  logic              out_valid;
  logic [CHAN_W-1:0] out_chan;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_char;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // stage 1 combinational results
  logic [EW-1:0]     cur;
  logic [MODE_W-1:0] cur_mode;
  logic [CW-1:0]     cur_count;
  logic [CW-1:0]     count_inc;
  logic [MODE_W-1:0] mode_next;
  logic [CW-1:0]     count_next;
  logic              s1_emit;
  logic [KIND_W-1:0] s1_kind;
  logic [BYTE_W-1:0] s1_char;
  logic              s1_adv;
  logic              s1_wr;
  logic              accept;
  logic              in_range;

  tla_chan_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // handshake
  assign s1_adv   = !s1_emit || !out_valid || events.ready;
  assign s1_wr    = s1_valid && s1_adv;
  assign rx.ready = !sweeping && (!s1_valid || s1_adv);
  assign accept   = rx.valid && rx.ready;
  assign in_range = int'(rx.channel) < CHANNELS;

  // memory access: sweep writes zero, otherwise stage 1 writes back
  assign rd_en   = accept;
  assign rd_addr = AW'(rx.channel);
  assign wr_en   = sweeping || s1_wr;
  assign wr_addr = sweeping ? sweep_addr : s1_addr;
  assign wr_data = sweeping ? '0 : {mode_next, count_next};

  // walk the memory once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == AW'(CHANNELS - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // advance stage 1; capture forwarded state when the write hits the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= in_range;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= rd_addr;
      s1_chan  <= rx.channel;
      s1_byte  <= rx.rx_byte;
      byp_hit  <= s1_wr && (s1_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign cur       = byp_hit ? byp_data : rd_data;
  assign cur_mode  = cur[EW-1:CW];
  assign cur_count = cur[CW-1:0];
  assign count_inc = cur_count + 1'b1;

  // parse one byte against the channel state
  always_comb begin
    mode_next  = M_TEXT;
    count_next = cur_count;
    s1_emit    = 1'b0;
    s1_kind    = EV_KEEP;
    s1_char    = '0;
    unique case (cur_mode)
      M_IAC: begin
        unique case (s1_byte)
          B_IP: begin
            count_next = '0;
            s1_emit    = 1'b1;
            s1_kind    = EV_DISCONN;
          end
          B_DO: begin
            mode_next = M_DO;
          end
          B_WILL, B_WONT, B_DONT: begin
            mode_next = M_SKIP;
          end
          B_AYT: begin
            s1_emit = 1'b1;
            s1_kind = EV_AYT;
          end
          B_EL: begin
            count_next = '0;
            s1_emit    = 1'b1;
            s1_kind    = EV_ERASE;
          end
          default: begin
          end
        endcase
      end
      M_SKIP: begin
      end
      M_DO: begin
        if (s1_byte == OPT_TM) begin
          s1_emit = 1'b1;
          s1_kind = EV_WILL_TM;
        end else if (s1_byte == OPT_SGA) begin
          s1_emit = 1'b1;
          s1_kind = EV_WILL_SGA;
        end
      end
      default: begin
        priority if (s1_byte == B_IAC) begin
          mode_next = M_IAC;
        end else if (s1_byte == B_NEWLINE) begin
          count_next = '0;
          s1_emit    = 1'b1;
          s1_kind    = EV_LINE_END;
        end else if (s1_byte >= B_SPACE) begin
          s1_emit = 1'b1;
          s1_char = s1_byte;
          if (count_inc >= COUNT_LAST) begin
            count_next = '0;
            s1_kind    = EV_LINE_FULL;
          end else begin
            count_next = count_inc;
            s1_kind    = EV_KEEP;
          end
        end else begin
          // drop other control bytes
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_emit && s1_adv) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_emit && s1_adv) begin
      out_chan <= s1_chan;
      out_kind <= s1_kind;
      out_char <= s1_char;
    end
  end

  assign events.valid       = out_valid;
  assign events.out_channel = out_chan;
  assign events.event_kind  = out_kind;
  assign events.char_out    = out_char;

  // no word enters while the memory is being cleared
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !rx.ready)
    else $error("word accepted during clearing pass");

  // a stalled stage 1 item stays put and writes nothing
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_addr) && $stable(s1_byte)))
    else $error("stage 1 item lost while stalled");

  // stored line count stays below the forced-end threshold
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (cur_count < COUNT_LAST))
    else $error("line count out of range, stale state forwarded");

  // a full, untaken output register never gets overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit && out_valid && !events.ready) |-> !s1_adv)
    else $error("pending event overwritten");

endmodule

@@ src/tla_chan_ram.sv @@
// tla_chan_ram: single-port-write, single-port-read channel state memory.
// Read data is registered and updates only when a read is issued.
// No dependencies.
module tla_chan_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 13,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for telnet_line_assembler.
// Drives channel/byte words, predicts each event per channel and checks every event word.
// Depends on tla_pkg, tla_in_if, tla_out_if and the telnet_line_assembler RTL.
module tb;
  import tla_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int LANES        = 4;
  localparam int HOT_LANE     = LANES;
  localparam int DRAIN_AT     = 500;
  localparam int TAIL_CYCLES  = 8;

  // Per-channel telnet parser copy; queues the events the block must produce.
  class telnet_event_board;
    typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] text;
    } line_event_t;

    line_event_t       pending[$];
    logic [MODE_W-1:0] mode [CHANNELS_DEFAULT];
    int unsigned       line_len [CHANNELS_DEFAULT];
    int unsigned       kind_count [8];
    int unsigned       bytes_taken;
    int unsigned       events_seen;
    int unsigned       errors;

    function new();
      foreach (mode[i]) begin
        mode[i] = M_TEXT;
        line_len[i] = 0;
      end
      foreach (kind_count[i]) kind_count[i] = 0;
      bytes_taken = 0;
      events_seen = 0;
      errors = 0;
    endfunction

    function void push_event(logic [CHAN_W-1:0] chan, logic [KIND_W-1:0] kind,
                             logic [BYTE_W-1:0] text);
      line_event_t ev;
      ev.chan = chan;
      ev.kind = kind;
      ev.text = text;
      pending.push_back(ev);
      kind_count[kind]++;
    endfunction

    // Advance the parser of one channel by one accepted word.
    function void note_byte(logic [CHAN_W-1:0] chan, logic [BYTE_W-1:0] data);
      logic [MODE_W-1:0] prior;
      int unsigned       grown;
      bytes_taken++;
      if (chan >= CHANNELS_DEFAULT) return;
      prior = mode[chan];
      mode[chan] = M_TEXT;
      case (prior)
        M_IAC: begin
          if (data == B_IP) begin
            line_len[chan] = 0;
            push_event(chan, EV_DISCONN, '0);
          end else if (data == B_DO) begin
            mode[chan] = M_DO;
          end else if (data == B_WILL || data == B_WONT || data == B_DONT) begin
            mode[chan] = M_SKIP;
          end else if (data == B_AYT) begin
            push_event(chan, EV_AYT, '0);
          end else if (data == B_EL) begin
            line_len[chan] = 0;
            push_event(chan, EV_ERASE, '0);
          end
        end
        M_SKIP: begin
        end
        M_DO: begin
          if (data == OPT_TM) push_event(chan, EV_WILL_TM, '0);
          else if (data == OPT_SGA) push_event(chan, EV_WILL_SGA, '0);
        end
        default: begin
          if (data == B_IAC) begin
            mode[chan] = M_IAC;
          end else if (data == B_NEWLINE) begin
            line_len[chan] = 0;
            push_event(chan, EV_LINE_END, '0);
          end else if (data >= B_SPACE) begin
            grown = line_len[chan] + 1;
            if (grown >= LINE_MAX_DEFAULT - 1) begin
              line_len[chan] = 0;
              push_event(chan, EV_LINE_FULL, data);
            end else begin
              line_len[chan] = grown;
              push_event(chan, EV_KEEP, data);
            end
          end
        end
      endcase
    endfunction

    // Compare one event word with the oldest queued event.
    function void check_event(logic [CHAN_W-1:0] chan, logic [KIND_W-1:0] kind,
                              logic [BYTE_W-1:0] text);
      line_event_t want;
      events_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: expected no event, got chan %h kind %0d char %h",
                 $time, chan, kind, text);
        return;
      end
      want = pending.pop_front();
      if (want.chan !== chan || want.kind !== kind || want.text !== text) begin
        errors++;
        $display("%0t: event mismatch: expected chan %h kind %0d char %h,",
                 $time, want.chan, want.kind, want.text,
                 " got chan %h kind %0d char %h", chan, kind, text);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tla_in_if  rx();
  tla_out_if events();

  telnet_line_assembler #(
    .CHANNELS(CHANNELS_DEFAULT),
    .LINE_MAX(LINE_MAX_DEFAULT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .events(events)
  );

  telnet_event_board board;

  int                burst_left;
  logic [CHAN_W-1:0] hot_chan;
  logic [CHAN_W-1:0] lane_chan [LANES+1];
  logic [BYTE_W-1:0] lane_bytes [LANES+1][$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.channel = '0;
    rx.rx_byte = '0;
    events.ready = 1'b0;
    board = new();
  end

  // Receiver: check every event word, stall in bursts with calm stretches.
  int unsigned rx_cycle = 0;
  int          stall_left = 0;
  always @(posedge clk) begin
    if (events.valid && events.ready)
      board.check_event(events.out_channel, events.event_kind, events.char_out);
    rx_cycle++;
    if (stall_left != 0) begin
      events.ready <= 1'b0;
      stall_left--;
    end else begin
      events.ready <= 1'b1;
      if ((rx_cycle / 300) % 3 != 2 && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 6);
    end
  end

  // Send one word; open a new burst after a random gap when the old one ends.
  task automatic send_byte(input logic [CHAN_W-1:0] chan, input logic [BYTE_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 16);
    end
    rx.valid <= 1'b1;
    rx.channel <= chan;
    rx.rx_byte <= data;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    board.note_byte(chan, data);
    burst_left--;
  endtask

  // Hold the sender until every queued event has come out.
  task automatic drain();
    rx.valid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] printable();
    return BYTE_W'($urandom_range(B_SPACE, B_IAC - 1));
  endfunction

  // Queue a telnet sequence for one lane: mostly well formed, some noise.
  function automatic void queue_sequence(int lane);
    int                pick;
    logic [CHAN_W-1:0] fresh;
    if (lane == HOT_LANE && board.kind_count[EV_LINE_FULL] == 0) begin
      // keep the hot line growing; only commands that leave the count alone
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        lane_bytes[lane].push_back(B_IAC);
        lane_bytes[lane].push_back(B_AYT);
      end else if (pick == 1) begin
        lane_bytes[lane].push_back(B_IAC);
        lane_bytes[lane].push_back(B_DO);
        lane_bytes[lane].push_back($urandom_range(0, 1) ? OPT_TM : OPT_SGA);
      end else begin
        repeat ($urandom_range(8, 40)) lane_bytes[lane].push_back(printable());
      end
      return;
    end
    if (lane != HOT_LANE && $urandom_range(0, 3) == 0) begin
      fresh = CHAN_W'($urandom_range(0, 255));
      while (fresh == hot_chan && board.kind_count[EV_LINE_FULL] == 0)
        fresh = CHAN_W'($urandom_range(0, 255));
      lane_chan[lane] = fresh;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 8)) lane_bytes[lane].push_back(printable());
      if ($urandom_range(0, 1)) lane_bytes[lane].push_back(B_NEWLINE);
    end else if (pick < 42) begin
      lane_bytes[lane].push_back(B_IAC);
      case ($urandom_range(0, 5))
        0: lane_bytes[lane].push_back(B_IP);
        1: lane_bytes[lane].push_back(B_AYT);
        2: lane_bytes[lane].push_back(B_EL);
        3: lane_bytes[lane].push_back(B_IAC);
        4: lane_bytes[lane].push_back(BYTE_W'($urandom_range(8'hF0, 8'hFF)));
        default: lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, 255)));
      endcase
    end else if (pick < 54) begin
      lane_bytes[lane].push_back(B_IAC);
      lane_bytes[lane].push_back(B_DO);
      case ($urandom_range(0, 2))
        0: lane_bytes[lane].push_back(OPT_TM);
        1: lane_bytes[lane].push_back(OPT_SGA);
        default: lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, 255)));
      endcase
    end else if (pick < 66) begin
      lane_bytes[lane].push_back(B_IAC);
      case ($urandom_range(0, 2))
        0: lane_bytes[lane].push_back(B_WILL);
        1: lane_bytes[lane].push_back(B_WONT);
        default: lane_bytes[lane].push_back(B_DONT);
      endcase
      lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 74) begin
      lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, B_SPACE - 1)));
    end else if (pick < 82) begin
      lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      // cut-off command: the next sequence lands in the middle of it
      lane_bytes[lane].push_back(B_IAC);
      case ($urandom_range(0, 2))
        0: lane_bytes[lane].push_back(B_DO);
        1: lane_bytes[lane].push_back(B_WILL);
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 12))
        lane_bytes[lane].push_back(BYTE_W'($urandom_range(0, 255)));
      lane_bytes[lane].push_back(B_NEWLINE);
    end
  endfunction

  // Stimulus: reset, directed words, then interleaved random lanes.
  initial begin
    logic [CHAN_W+BYTE_W-1:0] directed [$];
    int                       sent;
    int                       lane;

    directed = '{
      {8'd0, B_SPACE}, {8'd0, B_DONT}, {8'd255, 8'h41}, {8'd255, B_NEWLINE},
      {8'd0, 8'h1F}, {8'd0, 8'h00}, {8'd0, B_IAC}, {8'd0, B_IP},
      {8'd1, B_IAC}, {8'd1, B_AYT}, {8'd1, B_IAC}, {8'd1, B_EL},
      {8'd2, B_IAC}, {8'd2, B_DO}, {8'd2, OPT_TM},
      {8'd2, B_IAC}, {8'd2, B_DO}, {8'd2, OPT_SGA},
      {8'd3, B_IAC}, {8'd3, B_WILL}, {8'd3, B_IAC},
      {8'd3, B_IAC}, {8'd3, B_WONT}, {8'd3, OPT_TM},
      {8'd6, B_IAC}, {8'd6, B_DONT}, {8'd6, 8'h41}
    };
    burst_left = 0;
    sent = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_byte(directed[i][CHAN_W+BYTE_W-1:BYTE_W], directed[i][BYTE_W-1:0]);
    drain();

    // one hot channel fills a whole line while other lanes interleave
    hot_chan = CHAN_W'($urandom_range(0, 255));
    lane_chan[HOT_LANE] = hot_chan;
    for (int i = 0; i < LANES; i++) begin
      lane_chan[i] = CHAN_W'($urandom_range(0, 255));
      while (lane_chan[i] == hot_chan) lane_chan[i] = CHAN_W'($urandom_range(0, 255));
    end
    while (sent < RANDOM_WORDS || board.kind_count[EV_LINE_FULL] == 0) begin
      if (board.kind_count[EV_LINE_FULL] == 0 && $urandom_range(0, 7) != 0)
        lane = HOT_LANE;
      else lane = $urandom_range(0, LANES);
      if (lane_bytes[lane].size() == 0) queue_sequence(lane);
      send_byte(lane_chan[lane], lane_bytes[lane].pop_front());
      sent++;
      if (sent == DRAIN_AT) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words, checked %0d events: %0d kept, %0d line ends, %0d full lines,",
             board.bytes_taken, board.events_seen, board.kind_count[EV_KEEP],
             board.kind_count[EV_LINE_END], board.kind_count[EV_LINE_FULL]);
    $display("  %0d erases, %0d AYT, %0d TM, %0d SGA, %0d disconnects.",
             board.kind_count[EV_ERASE], board.kind_count[EV_AYT],
             board.kind_count[EV_WILL_TM], board.kind_count[EV_WILL_SGA],
             board.kind_count[EV_DISCONN]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(8 * 400000);
    $display("Timeout with %0d events outstanding", board.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ telnet_line_assembler.f @@
src/tla_pkg.sv
src/tla_if.sv
src/tla_chan_ram.sv
src/telnet_line_assembler.sv
tb/sv/tb.sv
